>>> hw/rtl/fbs_pkg.sv
`default_nettype none

package fbs_pkg;

    // Item commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Reset value of the preamble zero count
    localparam logic [3:0] PREAMBLE_ZEROS_RST = 4'd4;

    // Default frame buffer depth
    localparam int BUFFER_BYTES_DEF = 16;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PREAMBLE = 2'd1,
        PH_DATA     = 2'd2,
        PH_STOP     = 2'd3
    } t_phase;

    // Where the line level of an item comes from
    typedef enum logic [1:0] {
        LS_HOLD = 2'd0,
        LS_ZERO = 2'd1,
        LS_ONE  = 2'd2,
        LS_MEM  = 2'd3
    } t_line_src;

    // Sequencer decision for one item, carried to the result stage
    typedef struct packed {
        t_line_src  line_src;
        logic [2:0] bit_sel;
        logic       busy;
        logic       done;
    } t_step;

endpackage

`default_nettype wire

>>> hw/rtl/fbs_seq.sv
`default_nettype none

module fbs_seq #(
    parameter int BUFFER_BYTES = fbs_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [1:0]                      i_command,
    input  wire logic [3:0]                      i_last_index,
    input  wire logic [3:0]                      i_preamble_zeros,
    output logic      [$clog2(BUFFER_BYTES)-1:0] o_rd_addr,
    output fbs_pkg::t_step                       o_step
);
    import fbs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    t_phase          r_phase, n_phase;
    logic [4:0]      r_step_cnt, n_step_cnt;
    logic [AW-1:0]   r_byte, n_byte;
    logic [2:0]      r_bit, n_bit;
    logic [AW-1:0]   r_final, n_final;

    logic [4:0]      pz;
    logic [4:0]      step_inc;

    assign pz       = {1'b0, i_preamble_zeros};
    assign step_inc = r_step_cnt + 5'd1;

    // Buffer read address: byte being sent
    assign o_rd_addr = r_byte;

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_step_cnt <= 5'd0;
            r_byte     <= '0;
            r_bit      <= 3'd7;
            r_final    <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_step_cnt <= n_step_cnt;
            r_byte     <= n_byte;
            r_bit      <= n_bit;
            r_final    <= n_final;
        end
    end

    // Next state and per-item decision
    always_comb begin
        n_phase         = r_phase;
        n_step_cnt      = r_step_cnt;
        n_byte          = r_byte;
        n_bit           = r_bit;
        n_final         = r_final;
        o_step.line_src = LS_HOLD;
        o_step.bit_sel  = r_bit;
        o_step.done     = 1'b0;

        case (i_command)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    // saturate last index to the buffer end
                    if (int'(i_last_index) >= BUFFER_BYTES) begin
                        n_final = AW'(BUFFER_BYTES - 1);
                    end else begin
                        n_final = AW'(i_last_index);
                    end
                    n_phase    = PH_PREAMBLE;
                    n_step_cnt = 5'd0;
                    n_byte     = '0;
                    n_bit      = 3'd7;
                end
            end
            CMD_TICK: begin
                case (r_phase)
                    PH_PREAMBLE: begin
                        if (r_step_cnt < pz) begin
                            o_step.line_src = LS_ZERO;
                        end else if (r_step_cnt == pz) begin
                            o_step.line_src = LS_ONE;
                        end else if (r_step_cnt == pz + 5'd1) begin
                            o_step.line_src = LS_ZERO;
                        end else begin
                            o_step.line_src = LS_ONE;
                        end
                        n_step_cnt = step_inc;
                        if (step_inc >= pz + 5'd3) begin
                            n_phase    = PH_DATA;
                            n_step_cnt = 5'd0;
                        end
                    end
                    PH_DATA: begin
                        o_step.line_src = LS_MEM;
                        if (r_bit == 3'd0) begin
                            if (r_byte >= r_final) begin
                                n_phase    = PH_STOP;
                                n_step_cnt = 5'd0;
                            end else begin
                                n_byte = r_byte + AW'(1);
                            end
                            n_bit = 3'd7;
                        end else begin
                            n_bit = r_bit - 3'd1;
                        end
                    end
                    PH_STOP: begin
                        o_step.line_src = LS_ZERO;
                        n_step_cnt      = step_inc;
                        if (step_inc >= pz) begin
                            n_phase     = PH_IDLE;
                            n_step_cnt  = 5'd0;
                            n_byte      = '0;
                            n_bit       = 3'd7;
                            o_step.done = 1'b1;
                        end
                    end
                    default: begin
                        // idle tick drives the line low
                        o_step.line_src = LS_ZERO;
                    end
                endcase
            end
            default: begin
                // load and unknown commands leave the sequencer alone
            end
        endcase

        o_step.busy = (n_phase != PH_IDLE) || o_step.done;
    end

endmodule

`default_nettype wire

>>> hw/rtl/framed_bit_serializer_unit.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_command, i_byte_index, i_byte_value,
//                                                i_last_index
// out       output     o_out_valid / i_out_stall o_line_level, o_busy_res, o_frame_done
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (preamble zero count)
//
// One item per cycle while the output does not stall; after an item is accepted,
// its result passes the frame buffer read (synchronous memory) and then the output
// register. Reset is synchronous, active low; the buffer is not cleared.
// A stall on the output holds the output register and the buffer read stage, and
// the input stalls only when both are full.

module framed_bit_serializer_unit #(
    parameter int BUFFER_BYTES = fbs_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input items
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [3:0] i_byte_index,
    input  wire logic [7:0] i_byte_value,
    input  wire logic [3:0] i_last_index,
    // result items
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_line_level,
    output logic            o_busy_res,
    output logic            o_frame_done,
    // configuration
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data
);
    import fbs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic [7:0]    r_mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] rd_addr;

    logic [3:0]    r_pz;
    t_step         seq_step;
    t_step         r_s1;
    logic          r_s1_valid;
    logic          r_out_valid;
    logic          r_line;
    logic          r_busy;
    logic          r_done;
    logic          n_line;

    logic          accept;
    logic          advance;
    logic          load_ok;

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign load_ok     = accept && (i_command == CMD_LOAD)
                         && (int'(i_byte_index) < BUFFER_BYTES);
    assign o_cfg_ready = 1'b1;

    // Preamble zero count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pz <= PREAMBLE_ZEROS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pz <= i_cfg_data;
        end
    end

    // Sequencer
    fbs_seq #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_command        (i_command),
        .i_last_index     (i_last_index),
        .i_preamble_zeros (r_pz),
        .o_rd_addr        (rd_addr),
        .o_step           (seq_step)
    );

    // Frame buffer write port
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_mem[AW'(i_byte_index)] <= i_byte_value;
        end
    end

    // Frame buffer read port, only on accept so a held item keeps its data
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= seq_step;
        end
    end

    // Line level of the item in the read stage
    always_comb begin
        case (r_s1.line_src)
            LS_ZERO: n_line = 1'b0;
            LS_ONE:  n_line = 1'b1;
            LS_MEM:  n_line = r_rdata[r_s1.bit_sel];
            default: n_line = r_line;
        endcase
    end

    // Output register; r_line is also the held line level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_line      <= 1'b0;
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_line <= n_line;
                r_busy <= r_s1.busy;
                r_done <= r_s1.done;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_line;
    assign o_busy_res   = r_busy;
    assign o_frame_done = r_done;

    // A finished frame is always reported as busy on its last bit
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_busy_res)
        else $error("frame_done without busy_res");

    // Input stalls only when the read stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("input stalled with empty read stage");

    // A held read stage item is not lost
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && o_in_stall |=> r_s1_valid && $stable(r_rdata))
        else $error("read stage item lost under stall");

endmodule

`default_nettype wire
